### rtl/xbt_pkg.sv
// ----------------------------------------------------------------------------
// xbt_pkg
// Shared types and character codes for the XML byte tokenizer.
// ----------------------------------------------------------------------------
package xbt_pkg;

    localparam int CNT_OUT_W = 24;
    localparam logic [CNT_OUT_W-1:0] CNT_OUT_MAX = '1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_LT     = 8'h3C;  // <
    localparam logic [7:0] CH_GT     = 8'h3E;  // >
    localparam logic [7:0] CH_QMARK  = 8'h3F;  // ?
    localparam logic [7:0] CH_EQ     = 8'h3D;  // =
    localparam logic [7:0] CH_BANG   = 8'h21;  // !
    localparam logic [7:0] CH_SLASH  = 8'h2F;  // /
    localparam logic [7:0] CH_DQUOTE = 8'h22;  // "
    localparam logic [7:0] CH_SQUOTE = 8'h27;  // '
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // One classified item: an optional close-only result, then an optional
    // character result.
    typedef struct packed {
        logic                 has_close;
        logic                 has_char;
        logic [7:0]           ch;
        logic                 char_end;
        logic [CNT_OUT_W-1:0] line_no;
        logic [CNT_OUT_W-1:0] column_no;
    } t_entry;

endpackage

### rtl/xbt_front.sv
// ----------------------------------------------------------------------------
// xbt_front
// Accepts bytes, tracks token/quote state and position counters, and turns
// each transaction into at most one queue entry of up to two results.
// ----------------------------------------------------------------------------
module xbt_front
    import xbt_pkg::*;
#(
    parameter int COUNTER_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_kind,
    input  logic [7:0] i_byte_in,
    input  logic       i_char_data_mode,
    output logic       o_push,
    output t_entry     o_entry
);

    localparam int EXT_W = (COUNTER_BITS > CNT_OUT_W) ? COUNTER_BITS : CNT_OUT_W;

    logic                    r_token_open, n_token_open;
    logic                    r_in_quote, n_in_quote;
    logic                    r_quote_dbl, n_quote_dbl;
    logic [COUNTER_BITS-1:0] r_line, n_line;
    logic [COUNTER_BITS-1:0] r_col, n_col;

    logic       is_lit;
    logic       is_quote;
    logic [7:0] quote_ch;
    t_entry     ent;

    function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
        logic [COUNTER_BITS-1:0] r;
        r = (v == {COUNTER_BITS{1'b1}}) ? v : v + 1'b1;
        return r;
    endfunction

    function automatic logic [CNT_OUT_W-1:0] clip(input logic [COUNTER_BITS-1:0] v);
        logic [EXT_W-1:0]     ext;
        logic [CNT_OUT_W-1:0] r;
        ext = EXT_W'(v);
        r   = (ext > EXT_W'(CNT_OUT_MAX)) ? CNT_OUT_MAX : ext[CNT_OUT_W-1:0];
        return r;
    endfunction

    always_comb begin
        is_lit = (i_byte_in == CH_LT) || (i_byte_in == CH_GT) ||
                 (!i_char_data_mode &&
                  ((i_byte_in == CH_QMARK) || (i_byte_in == CH_EQ) ||
                   (i_byte_in == CH_BANG) || (i_byte_in == CH_SLASH)));
        is_quote = (i_byte_in == CH_DQUOTE) || (i_byte_in == CH_SQUOTE);
        quote_ch = r_quote_dbl ? CH_DQUOTE : CH_SQUOTE;
    end

    always_comb begin
        n_token_open = r_token_open;
        n_in_quote   = r_in_quote;
        n_quote_dbl  = r_quote_dbl;
        n_line       = r_line;
        n_col        = r_col;
        ent          = '0;

        if (i_kind == KIND_EOS) begin
            ent.has_close = r_token_open || r_in_quote;
            n_token_open  = 1'b0;
            n_in_quote    = 1'b0;
        end else begin
            n_col = sat_inc(r_col);
            if (r_in_quote) begin
                ent.has_char = 1'b1;
                ent.ch       = i_byte_in;
                ent.char_end = (i_byte_in == quote_ch);
                if (i_byte_in == quote_ch) begin
                    n_in_quote   = 1'b0;
                    n_token_open = 1'b0;
                end
            end else if (is_lit) begin
                ent.has_close = r_token_open;
                ent.has_char  = 1'b1;
                ent.ch        = i_byte_in;
                ent.char_end  = 1'b1;
                n_token_open  = 1'b0;
            end else if (i_char_data_mode) begin
                ent.has_char = 1'b1;
                ent.ch       = i_byte_in;
                n_token_open = 1'b1;
            end else if (is_quote) begin
                // a quote mid-token closes the token and opens a quoted one
                ent.has_close = r_token_open;
                ent.has_char  = 1'b1;
                ent.ch        = i_byte_in;
                n_token_open  = 1'b1;
                n_in_quote    = 1'b1;
                n_quote_dbl   = (i_byte_in == CH_DQUOTE);
            end else if ((i_byte_in == CH_SPACE) || (i_byte_in == CH_TAB)) begin
                ent.has_close = r_token_open;
                n_token_open  = 1'b0;
            end else if (i_byte_in == CH_LF) begin
                n_line = sat_inc(r_line);
                n_col  = COUNTER_BITS'(1);
            end else if (i_byte_in != CH_CR) begin
                ent.has_char = 1'b1;
                ent.ch       = i_byte_in;
                n_token_open = 1'b1;
            end
        end
        ent.line_no   = clip(n_line);
        ent.column_no = clip(n_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_open <= 1'b0;
            r_in_quote   <= 1'b0;
            r_quote_dbl  <= 1'b0;
            r_line       <= '0;
            r_col        <= '0;
        end else if (i_accept) begin
            r_token_open <= n_token_open;
            r_in_quote   <= n_in_quote;
            r_quote_dbl  <= n_quote_dbl;
            r_line       <= n_line;
            r_col        <= n_col;
        end
    end

    assign o_push  = i_accept && (ent.has_close || ent.has_char);
    assign o_entry = ent;

    a_quote_in_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_quote |-> r_token_open)
        else $error("quoted state without an open token");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_kind == KIND_EOS) |=> (!r_token_open && !r_in_quote))
        else $error("end of stream left a token open");

    a_eos_holds_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_kind == KIND_EOS) |=> ($stable(r_line) && $stable(r_col)))
        else $error("end of stream moved the position counters");

endmodule

### rtl/xbt_queue.sv
// ----------------------------------------------------------------------------
// xbt_queue
// Short entry queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module xbt_queue
    import xbt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_head_valid,
    output t_entry o_head
);

    t_entry              r_slot [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full       = (r_count == QCNT_W'(QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_head_valid |-> !i_pop)
        else $error("pop from an empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

endmodule

### rtl/xbt_back.sv
// ----------------------------------------------------------------------------
// xbt_back
// Output sequencer: splits each queue entry into its results and holds them
// in the output register until taken.
// ----------------------------------------------------------------------------
module xbt_back
    import xbt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  t_entry               i_head,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [7:0]           o_out_char,
    output logic                 o_char_valid,
    output logic                 o_token_end,
    output logic [CNT_OUT_W-1:0] o_line_no,
    output logic [CNT_OUT_W-1:0] o_column_no
);

    logic r_valid;
    logic r_phase;        // close result of the head entry already sent
    logic load;
    logic send_close;

    assign load       = !r_valid || !i_stall;
    assign send_close = i_head.has_close && !r_phase;
    assign o_pop      = load && i_head_valid && !(send_close && i_head.has_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= i_head_valid;
            if (i_head_valid) begin
                r_phase <= send_close && i_head.has_char;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head_valid) begin
            o_line_no   <= i_head.line_no;
            o_column_no <= i_head.column_no;
            if (send_close) begin
                o_out_char   <= 8'h00;
                o_char_valid <= 1'b0;
                o_token_end  <= 1'b1;
            end else begin
                o_out_char   <= i_head.ch;
                o_char_valid <= 1'b1;
                o_token_end  <= i_head.char_end;
            end
        end
    end

    assign o_valid = r_valid;

    a_phase_shows_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_valid && !o_char_valid && o_token_end))
        else $error("split entry without its close result on the output");

    a_phase_head_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (i_head_valid && i_head.has_char))
        else $error("split entry lost from the queue head");

    a_split_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_head_valid && send_close && i_head.has_char) |-> !o_pop)
        else $error("entry popped before its character result");

endmodule

### rtl/xml_byte_tokenizer.sv
// ----------------------------------------------------------------------------
// xml_byte_tokenizer
// Streaming XML lexical tokenizer: one byte in, token characters out.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with i_kind (0 data byte, 1 end of stream),
// i_byte_in and i_char_data_mode. A transaction is taken when i_valid is high
// and o_stall is low. Output channel: o_valid / i_stall with o_out_char,
// o_char_valid, o_token_end, o_line_no and o_column_no; each transaction is one
// token character or a close-only mark (o_char_valid low, o_token_end high).
// Each input byte is classified in the cycle it is taken and yields zero, one
// or two results; the classified entry goes through a four-entry queue to the
// output register. Input rate is one byte per cycle while o_stall is low;
// output rate is one result per cycle while i_stall is low, so a byte that
// yields two results makes two output transactions and the queue absorbs the
// difference. o_stall rises only when the queue is full, which happens when
// i_stall is held or when two-result bytes keep arriving back to back; a full
// queue holds o_stall for that cycle even if it drains an entry. Results held
// under i_stall stay in the output register. Synchronous reset clears token
// state, the position counters and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module xml_byte_tokenizer
    import xbt_pkg::*;
#(
    parameter int COUNTER_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_kind,
    input  logic [7:0]           i_byte_in,
    input  logic                 i_char_data_mode,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_out_char,
    output logic                 o_char_valid,
    output logic                 o_token_end,
    output logic [CNT_OUT_W-1:0] o_line_no,
    output logic [CNT_OUT_W-1:0] o_column_no
);

    logic   accept;
    logic   push;
    logic   pop;
    logic   full;
    logic   head_valid;
    t_entry entry;
    t_entry head;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    xbt_front #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_kind           (i_kind),
        .i_byte_in        (i_byte_in),
        .i_char_data_mode (i_char_data_mode),
        .o_push           (push),
        .o_entry          (entry)
    );

    xbt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (entry),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    xbt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_char   (o_out_char),
        .o_char_valid (o_char_valid),
        .o_token_end  (o_token_end),
        .o_line_no    (o_line_no),
        .o_column_no  (o_column_no)
    );

endmodule

### tb/tb_xml_byte_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_xml_byte_tokenizer
// Self-checking bench for the streaming XML byte tokenizer. A short table of
// directed bytes runs first, then generated XML fragments with random content
// and some raw noise. A model in the bench predicts the token characters, the
// close marks and the line/column position for every accepted transaction.
// ----------------------------------------------------------------------------
module tb_xml_byte_tokenizer;
    import xbt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_ITEMS = 900;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0]           ch;
        logic                 cv;
        logic                 te;
        logic [CNT_OUT_W-1:0] line_no;
        logic [CNT_OUT_W-1:0] col_no;
    } t_token_res;

    typedef struct {
        logic       kind;
        logic [7:0] data;
        logic       cdata;
        int         n_typed;  // -1: take the prediction
        t_token_res r0;
        t_token_res r1;
    } t_byte_item;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_RUNS, STALL_PERIODIC} t_stall_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_kind = KIND_DATA;
    logic [7:0]           i_byte_in = 8'h00;
    logic                 i_char_data_mode = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [7:0]           o_out_char;
    logic                 o_char_valid;
    logic                 o_token_end;
    logic [CNT_OUT_W-1:0] o_line_no;
    logic [CNT_OUT_W-1:0] o_column_no;

    xml_byte_tokenizer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_byte_in        (i_byte_in),
        .i_char_data_mode (i_char_data_mode),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_char       (o_out_char),
        .o_char_valid     (o_char_valid),
        .o_token_end      (o_token_end),
        .o_line_no        (o_line_no),
        .o_column_no      (o_column_no)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Tokenizer model state
    logic                 tok_open = 1'b0;
    logic                 quoted = 1'b0;
    logic                 quote_dq = 1'b0;
    logic [CNT_OUT_W-1:0] line_cnt = '0;
    logic [CNT_OUT_W-1:0] col_cnt = '0;

    t_token_res step_tokens[$];
    t_token_res expected_tokens[$];
    t_byte_item stim_items[$];

    int n_directed = 0;
    int n_accepted = 0;
    int n_eos = 0;
    int n_checked = 0;
    int n_closes = 0;
    int n_errors = 0;
    int burst_left = 0;
    int cycle_count = 0;

    task automatic emit(input logic [7:0] ch, input logic cv, input logic te);
        step_tokens.push_back('{ch, cv, te, line_cnt, col_cnt});
    endtask

    task automatic tokenize_byte(input logic kind, input logic [7:0] b, input logic cd);
        logic       lit;
        logic [7:0] q;
        step_tokens.delete();
        lit = (b == CH_LT) || (b == CH_GT) ||
              (!cd && (b == CH_QMARK || b == CH_EQ || b == CH_BANG || b == CH_SLASH));
        q = quote_dq ? CH_DQUOTE : CH_SQUOTE;
        if (kind == KIND_EOS) begin
            // end of stream closes whatever is pending
            if (tok_open || quoted)
                emit(8'h00, 1'b0, 1'b1);
            tok_open = 1'b0;
            quoted = 1'b0;
        end else begin
            if (col_cnt != CNT_OUT_MAX)
                col_cnt = col_cnt + 1'b1;
            if (quoted) begin
                emit(b, 1'b1, b == q);
                if (b == q) begin
                    quoted = 1'b0;
                    tok_open = 1'b0;
                end
            end else if (lit) begin
                if (tok_open)
                    emit(8'h00, 1'b0, 1'b1);
                emit(b, 1'b1, 1'b1);
                tok_open = 1'b0;
            end else if (cd) begin
                emit(b, 1'b1, 1'b0);
                tok_open = 1'b1;
            end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                // a quote inside a token closes it first
                if (tok_open)
                    emit(8'h00, 1'b0, 1'b1);
                emit(b, 1'b1, 1'b0);
                tok_open = 1'b1;
                quoted = 1'b1;
                quote_dq = (b == CH_DQUOTE);
            end else if (b == CH_SPACE || b == CH_TAB) begin
                if (tok_open)
                    emit(8'h00, 1'b0, 1'b1);
                tok_open = 1'b0;
            end else if (b == CH_LF) begin
                if (line_cnt != CNT_OUT_MAX)
                    line_cnt = line_cnt + 1'b1;
                col_cnt = CNT_OUT_W'(1);
            end else if (b != CH_CR) begin
                emit(b, 1'b1, 1'b0);
                tok_open = 1'b1;
            end
        end
    endtask

    task automatic add_row(input logic kind, input logic [7:0] b, input logic cd,
                           input int n_typed = -1, input t_token_res r0 = '0,
                           input t_token_res r1 = '0);
        t_byte_item it;
        it.kind = kind;
        it.data = b;
        it.cdata = cd;
        it.n_typed = n_typed;
        it.r0 = r0;
        it.r1 = r1;
        stim_items.push_back(it);
    endtask

    function automatic logic [7:0] pick_text_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 8'($urandom_range(8'h21, 8'h7E));
        else if (r == 7)
            return 8'($urandom_range(8'h80, 8'hFF));
        else if (r == 8)
            return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
        else
            return ($urandom_range(0, 1) != 0) ? CH_LF : CH_CR;
    endfunction

    task automatic add_name();
        repeat ($urandom_range(1, 6))
            add_row(KIND_DATA, 8'($urandom_range(8'h61, 8'h7A)), 1'b0);
    endtask

    task automatic add_space();
        repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(0, 5))
                0:       add_row(KIND_DATA, CH_TAB, 1'b0);
                1:       add_row(KIND_DATA, CH_LF, 1'b0);
                2:       add_row(KIND_DATA, CH_CR, 1'b0);
                default: add_row(KIND_DATA, CH_SPACE, 1'b0);
            endcase
        end
    endtask

    task automatic add_attr();
        logic [7:0] q;
        logic [7:0] c;
        add_space();
        add_name();
        add_row(KIND_DATA, CH_EQ, 1'b0);
        q = ($urandom_range(0, 1) != 0) ? CH_DQUOTE : CH_SQUOTE;
        add_row(KIND_DATA, q, 1'b0);
        repeat ($urandom_range(0, 8)) begin
            c = pick_text_char();
            if (c == q)
                c = 8'h78;
            add_row(KIND_DATA, c, 1'($urandom_range(0, 1)));
        end
        add_row(KIND_DATA, q, 1'b0);
    endtask

    // Mostly well-formed markup with random content, some noise and stream ends
    task automatic add_fragment();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12) begin
            add_row(KIND_DATA, CH_LT, 1'b0);
            add_name();
            repeat ($urandom_range(0, 2))
                add_attr();
            if ($urandom_range(0, 3) == 0) begin
                add_row(KIND_DATA, CH_SLASH, 1'b0);
                add_row(KIND_DATA, CH_GT, 1'b0);
            end else begin
                add_row(KIND_DATA, CH_GT, 1'b0);
                repeat ($urandom_range(0, 12))
                    add_row(KIND_DATA, pick_text_char(), 1'b1);
                add_row(KIND_DATA, CH_LT, 1'b1);
                add_row(KIND_DATA, CH_SLASH, 1'b0);
                add_name();
                add_row(KIND_DATA, CH_GT, 1'b0);
            end
            if ($urandom_range(0, 1) != 0)
                add_row(KIND_DATA, CH_LF, 1'b0);
        end else if (sel < 14) begin
            add_row(KIND_DATA, CH_LT, 1'b0);
            add_row(KIND_DATA, CH_QMARK, 1'b0);
            add_name();
            add_attr();
            add_row(KIND_DATA, CH_QMARK, 1'b0);
            add_row(KIND_DATA, CH_GT, 1'b0);
        end else if (sel < 15) begin
            add_row(KIND_DATA, CH_LT, 1'b0);
            add_row(KIND_DATA, CH_BANG, 1'b0);
            add_row(KIND_DATA, 8'h2D, 1'b0);
            add_row(KIND_DATA, 8'h2D, 1'b0);
            repeat ($urandom_range(0, 10))
                add_row(KIND_DATA, pick_text_char(), 1'b0);
            add_row(KIND_DATA, 8'h2D, 1'b0);
            add_row(KIND_DATA, 8'h2D, 1'b0);
            add_row(KIND_DATA, CH_GT, 1'b0);
        end else if (sel < 18) begin
            repeat ($urandom_range(1, 8))
                add_row(($urandom_range(0, 7) == 0) ? KIND_EOS : KIND_DATA,
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (sel == 18) begin
            add_row(KIND_EOS, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
            add_space();
        end
    endtask

    task automatic send_item(input t_byte_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                i_kind <= 1'($urandom_range(0, 1));
                i_byte_in <= 8'($urandom_range(0, 255));
                i_char_data_mode <= 1'($urandom_range(0, 1));
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_kind <= it.kind;
        i_byte_in <= it.data;
        i_char_data_mode <= it.cdata;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        n_accepted++;
        if (it.kind == KIND_EOS)
            n_eos++;
        tokenize_byte(it.kind, it.data, it.cdata);
        if (it.n_typed < 0) begin
            foreach (step_tokens[i])
                expected_tokens.push_back(step_tokens[i]);
        end else begin
            if (it.n_typed > 0)
                expected_tokens.push_back(it.r0);
            if (it.n_typed > 1)
                expected_tokens.push_back(it.r1);
        end
    endtask

    // Receiver stall pattern
    initial begin
        t_stall_mode mode;
        int          span;
        int          run;
        logic        level;
        level = 1'b0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(16, 160);
            while (span > 0) begin
                case (mode)
                    STALL_NONE: begin
                        run = span;
                        level = 1'b0;
                    end
                    STALL_RANDOM: begin
                        run = 1;
                        level = ($urandom_range(0, 2) == 0);
                    end
                    STALL_RUNS: begin
                        run = $urandom_range(1, 8);
                        level = ~level;
                    end
                    default: begin
                        run = 1;
                        level = (span % 3 == 0);
                    end
                endcase
                if (run > span)
                    run = span;
                repeat (run) begin
                    @(negedge i_clk);
                    i_stall <= level;
                end
                span -= run;
            end
        end
    end

    // Output checker
    always @(posedge i_clk) begin
        t_token_res got;
        t_token_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_out_char, o_char_valid, o_token_end, o_line_no, o_column_no};
            if (expected_tokens.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected output: ch=%02h cv=%0b te=%0b line=%0d col=%0d",
                             got.ch, got.cv, got.te, got.line_no, got.col_no);
            end else begin
                want = expected_tokens.pop_front();
                n_checked++;
                if (want.te)
                    n_closes++;
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("mismatch at output %0d:", n_checked);
                        $display("  exp ch=%02h cv=%0b te=%0b line=%0d col=%0d",
                                 want.ch, want.cv, want.te, want.line_no, want.col_no);
                        $display("  got ch=%02h cv=%0b te=%0b line=%0d col=%0d",
                                 got.ch, got.cv, got.te, got.line_no, got.col_no);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout: %0d results still pending", expected_tokens.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        // Directed table; the first rows carry hand-typed results
        add_row(KIND_DATA, CH_LT, 1'b0, 1, '{CH_LT, 1'b1, 1'b1, 24'd0, 24'd1});
        add_row(KIND_DATA, 8'h61, 1'b0, 1, '{8'h61, 1'b1, 1'b0, 24'd0, 24'd2});
        add_row(KIND_DATA, CH_EQ, 1'b0, 2, '{8'h00, 1'b0, 1'b1, 24'd0, 24'd3},
                '{CH_EQ, 1'b1, 1'b1, 24'd0, 24'd3});
        add_row(KIND_EOS, 8'hFF, 1'b0, 0);
        add_row(KIND_DATA, CH_SPACE, 1'b0);
        add_row(KIND_DATA, 8'h00, 1'b0);
        add_row(KIND_DATA, CH_TAB, 1'b0);
        add_row(KIND_DATA, CH_DQUOTE, 1'b0);
        add_row(KIND_DATA, CH_GT, 1'b1);
        add_row(KIND_DATA, CH_LF, 1'b0);
        add_row(KIND_DATA, CH_SQUOTE, 1'b0);
        add_row(KIND_DATA, CH_DQUOTE, 1'b0);
        add_row(KIND_DATA, CH_SQUOTE, 1'b0);
        add_row(KIND_DATA, 8'hFF, 1'b0);
        add_row(KIND_DATA, CH_SQUOTE, 1'b0);
        add_row(KIND_DATA, 8'h62, 1'b0);
        add_row(KIND_DATA, CH_DQUOTE, 1'b0);
        add_row(KIND_EOS, 8'h00, 1'b1);
        add_row(KIND_DATA, CH_LF, 1'b0);
        add_row(KIND_DATA, CH_CR, 1'b0);
        add_row(KIND_DATA, 8'h64, 1'b1);
        add_row(KIND_DATA, CH_QMARK, 1'b1);
        add_row(KIND_DATA, CH_SPACE, 1'b1);
        add_row(KIND_DATA, CH_LF, 1'b1);
        add_row(KIND_DATA, CH_BANG, 1'b0);
        add_row(KIND_DATA, CH_SLASH, 1'b0);
        add_row(KIND_DATA, 8'h66, 1'b1);
        add_row(KIND_DATA, CH_LT, 1'b1);
        n_directed = stim_items.size();
        while (stim_items.size() < n_directed + RANDOM_ITEMS)
            add_fragment();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_items[i])
            send_item(stim_items[i]);
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d byte transactions (%0d directed, %0d end-of-stream marks).",
                 n_accepted, n_directed, n_eos);
        $display("Checked %0d token transactions, %0d token closes, ended at line %0d.",
                 n_checked, n_closes, line_cnt);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
